// File: src/tws_pkg.sv
// ----------------------------------------------------------------------------
// Two-way time sync package
// Shared constants, codes and transaction types of the time sync engine.
// ----------------------------------------------------------------------------
package tws_pkg;

	localparam int ADDR_BITS = 16;
	localparam int TIME_BITS = 32;

	typedef enum logic [2:0] {
		CMD_TICK   = 3'd0,
		CMD_START  = 3'd1,
		CMD_RESYNC = 3'd2,
		CMD_CHECK  = 3'd3,
		CMD_SET    = 3'd4,
		CMD_RECV   = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		PH_SYNC   = 3'd0,
		PH_ACK    = 3'd1,
		PH_SET    = 3'd2,
		PH_RESYNC = 3'd3,
		PH_CHECK  = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE     = 2'd0,
		ST_WAIT_ACK = 2'd1,
		ST_WAIT_SET = 2'd2,
		ST_SYNCED   = 2'd3
	} sync_state_t;

	typedef struct packed {
		cmd_t                 cmd;
		logic [ADDR_BITS-1:0] peer_addr;
		phase_t               msg_phase;
		logic [TIME_BITS-1:0] msg_timestamp;
		logic                 msg_is_timesync;
		logic [TIME_BITS-1:0] set_value;
	} req_t;

	typedef struct packed {
		logic                 send_valid;
		phase_t               send_phase;
		logic [ADDR_BITS-1:0] send_addr;
		logic [TIME_BITS-1:0] send_timestamp;
		logic                 hot_wait;
		logic [TIME_BITS-1:0] sync_time;
	} rsp_t;

	typedef struct packed {
		logic valid;
		req_t item;
	} stage_t;

endpackage

// File: src/two_way_time_sync_engine_unit.sv
// ----------------------------------------------------------------------------
// Two-way time sync engine
// Keeps a local millisecond count, an offset and a link latency, and runs the
// SYNC, ACK, SET handshake that measures the round trip to a peer.
// ----------------------------------------------------------------------------
// Each request transaction yields exactly one result transaction, which passes
// through the input register and then the result register, each holding one
// transaction. A new request can be taken every cycle while the consumer is
// ready, and all state updates for a request are registered as its result is
// loaded. The local count advances only on tick commands.
module two_way_time_sync_engine_unit import tws_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	stage_t stage_s1;
	rsp_t   result;
	logic   advance;

	tws_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.advance  (advance),
		.stage_s1 (stage_s1)
	);

	tws_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.stage_s1(stage_s1),
		.advance (advance),
		.result  (result)
	);

	tws_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_valid(stage_s1.valid),
		.result    (result),
		.advance   (advance),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// File: src/tws_in_stage.sv
// ----------------------------------------------------------------------------
// Input stage
// Registers an accepted request transaction and holds it until the result
// stage can take its result.
// ----------------------------------------------------------------------------
module tws_in_stage import tws_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   req_valid,
	output logic   req_ready,
	input  req_t   req,
	input  logic   advance,
	output stage_t stage_s1
);

	logic valid_s1;
	req_t item_s1;

	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req;
		end
	end

	assign stage_s1.valid = valid_s1;
	assign stage_s1.item  = item_s1;

endmodule

// File: src/tws_engine.sv
// ----------------------------------------------------------------------------
// Sync engine
// Holds the local counter, offset, latency and handshake state, and works out
// the outgoing message and synced time for the request in the input stage.
// ----------------------------------------------------------------------------
module tws_engine import tws_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  stage_t stage_s1,
	input  logic   advance,
	output rsp_t   result
);

	logic [TIME_BITS-1:0] local_q;
	logic [TIME_BITS-1:0] offset_q;
	logic [TIME_BITS-1:0] latency_q;
	sync_state_t          state_q;

	logic [TIME_BITS-1:0] local_d;
	logic [TIME_BITS-1:0] offset_d;
	logic [TIME_BITS-1:0] latency_d;
	sync_state_t          state_d;
	logic [TIME_BITS-1:0] synced_now;
	logic [TIME_BITS-1:0] half_trip;
	logic                 fire;
	req_t                 it;

	assign fire       = stage_s1.valid && advance;
	assign it         = stage_s1.item;
	assign synced_now = local_q + offset_q;
	assign half_trip  = (local_q - latency_q) >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_q   <= '0;
			offset_q  <= '0;
			latency_q <= '0;
			state_q   <= ST_IDLE;
		end else if (fire) begin
			local_q   <= local_d;
			offset_q  <= offset_d;
			latency_q <= latency_d;
			state_q   <= state_d;
		end
	end

	always_comb begin
		local_d               = local_q;
		offset_d              = offset_q;
		latency_d             = latency_q;
		state_d               = state_q;
		result.send_valid     = 1'b0;
		result.send_phase     = PH_SYNC;
		result.send_addr      = '0;
		result.send_timestamp = '0;
		unique case (it.cmd)
			CMD_TICK: begin
				local_d = local_q + TIME_BITS'(1);
			end
			CMD_START: begin
				result.send_valid     = 1'b1;
				result.send_phase     = PH_SYNC;
				result.send_addr      = it.peer_addr;
				result.send_timestamp = synced_now;
				state_d               = ST_WAIT_ACK;
			end
			CMD_RESYNC: begin
				result.send_valid     = 1'b1;
				result.send_phase     = PH_RESYNC;
				result.send_addr      = it.peer_addr;
				result.send_timestamp = synced_now;
			end
			CMD_CHECK: begin
				result.send_valid     = 1'b1;
				result.send_phase     = PH_CHECK;
				result.send_addr      = it.peer_addr;
				result.send_timestamp = synced_now;
			end
			CMD_SET: begin
				offset_d = it.set_value - local_q;
			end
			CMD_RECV: begin
				if (it.msg_is_timesync) begin
					unique case (it.msg_phase)
						PH_CHECK: begin
							result.send_valid     = 1'b1;
							result.send_phase     = PH_ACK;
							result.send_addr      = it.peer_addr;
							result.send_timestamp = synced_now + latency_q;
						end
						PH_SYNC: begin
							if (state_q == ST_IDLE || state_q == ST_SYNCED) begin
								latency_d             = local_q;
								result.send_valid     = 1'b1;
								result.send_phase     = PH_ACK;
								result.send_addr      = it.peer_addr;
								result.send_timestamp = synced_now;
								state_d               = ST_WAIT_SET;
							end
						end
						PH_RESYNC: begin
							if (state_q == ST_SYNCED) begin
								offset_d = it.msg_timestamp + latency_q - local_q;
							end
						end
						PH_ACK: begin
							if (state_q == ST_WAIT_ACK) begin
								result.send_valid     = 1'b1;
								result.send_phase     = PH_SET;
								result.send_addr      = it.peer_addr;
								result.send_timestamp = synced_now;
								state_d               = ST_IDLE;
							end
						end
						PH_SET: begin
							if (state_q == ST_WAIT_SET) begin
								latency_d = half_trip;
								offset_d  = it.msg_timestamp + half_trip - local_q;
								state_d   = ST_SYNCED;
							end
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase
		result.hot_wait  = (state_d == ST_WAIT_ACK) || (state_d == ST_WAIT_SET);
		result.sync_time = local_d + offset_d;
	end

endmodule

// File: src/tws_out_stage.sv
// ----------------------------------------------------------------------------
// Result stage
// Holds the finished result transaction until the consumer takes it and
// tells the earlier stages when they may move on.
// ----------------------------------------------------------------------------
module tws_out_stage import tws_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   load_valid,
	input  rsp_t   result,
	output logic   advance,
	output logic   rsp_valid,
	input  logic   rsp_ready,
	output rsp_t   rsp
);

	logic rsp_valid_q;
	rsp_t rsp_q;

	assign advance   = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load_valid) begin
			rsp_q <= result;
		end
	end

endmodule

// File: src/tws_checker.sv
// ----------------------------------------------------------------------------
// Time sync engine checker
// Port-level assertions on the time sync engine, bound to the top level.
// ----------------------------------------------------------------------------
module tws_checker import tws_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request stalled with empty result stage");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.send_valid |->
			rsp.send_phase == PH_SYNC && rsp.send_addr == '0 && rsp.send_timestamp == '0)
		else $error("message fields set without a message");

	a_send_phase: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.send_valid |->
			rsp.send_phase == PH_SYNC || rsp.send_phase == PH_ACK ||
			rsp.send_phase == PH_SET || rsp.send_phase == PH_RESYNC ||
			rsp.send_phase == PH_CHECK)
		else $error("unknown outgoing phase");

endmodule

bind two_way_time_sync_engine_unit tws_checker u_tws_checker (.*);
